/* sv/bounding_volume_overlap_test_macros.svh */
// Assertion macros shared by the bounding volume overlap test.
`ifndef BOUNDING_VOLUME_OVERLAP_TEST_MACROS_SVH
`define BOUNDING_VOLUME_OVERLAP_TEST_MACROS_SVH
// Checks that an implication holds on every clock edge outside reset.
`define BVO_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("implication failed");
// Checks that an implication holds in the following cycle.
`define BVO_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("next-cycle implication failed");
`endif

/* sv/bvo_pkg.sv */
// Package with command codes, volume kinds and widths for the overlap test.
`timescale 1ns / 1ps
package bvo_pkg;
    localparam logic [1:0] CMD_INTERSECT = 2'd0;
    localparam logic [1:0] CMD_CONTAIN = 2'd1;
    localparam logic [1:0] CMD_POINT = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_BOX = 1'b1;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [2:0] REG_KIND = 3'd0;
    localparam logic [2:0] REG_CX = 3'd1;
    localparam logic [2:0] REG_CY = 3'd2;
    localparam logic [2:0] REG_CZ = 3'd3;
    localparam logic [2:0] REG_SX = 3'd4;
    localparam logic [2:0] REG_SY = 3'd5;
    localparam logic [2:0] REG_SZ = 3'd6;
endpackage

/* sv/bvo_axis.sv */
// One axis of the overlap test: differences, comparisons and squares over two stages.
`timescale 1ns / 1ps
module bvo_axis
    import bvo_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [COORD_BITS-1:0] i_qc,
    input  logic        [COORD_BITS-2:0] i_qh,
    input  logic signed [COORD_BITS-1:0] i_oc,
    input  logic        [COORD_BITS-2:0] i_oh,
    input  logic                        i_q_box,
    input  logic        [COORD_BITS-2:0] i_r,
    output logic      [2*COORD_BITS+1:0] o_gap_sq,
    output logic      [2*COORD_BITS+1:0] o_far_sq,
    output logic      [2*COORD_BITS+1:0] o_ctr_sq,
    output logic                        o_bb_isect,
    output logic                        o_bb_size_ok,
    output logic                        o_bb_inside,
    output logic                        o_face,
    output logic                        o_pt_in
);
    localparam int W = COORD_BITS + 2;
    localparam int P = 2 * W;

    logic signed [W-1:0] n_d, n_dl, n_du, n_pc, n_blo, n_bup;
    logic signed [W-1:0] qlo, qup, olo, oup;
    logic [W-1:0] r_ad, r_ag, r_af;
    logic r_bb_isect, r_bb_size_ok, r_bb_inside, r_face, r_pt_in;
    logic [P-1:0] r_ctr, r_gap, r_far;
    logic signed [W-1:0] gl, gu;
    logic [W-1:0] al, au;

    always_comb begin
        qlo = W'(i_qc) - W'(i_qh);
        qup = W'(i_qc) + W'(i_qh);
        olo = W'(i_oc) - W'(i_oh);
        oup = W'(i_oc) + W'(i_oh);
        n_d = W'(i_qc) - W'(i_oc);
        // The sphere center and the box bounds depend on which role the query plays.
        if (i_q_box) begin
            n_pc = W'(i_oc);
            n_blo = qlo;
            n_bup = qup;
        end else begin
            n_pc = W'(i_qc);
            n_blo = olo;
            n_bup = oup;
        end
        gl = n_pc - n_blo;
        gu = n_pc - n_bup;
        al = gl[W-1] ? -gl : gl;
        au = gu[W-1] ? -gu : gu;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad <= n_d[W-1] ? W'(-n_d) : W'(n_d);
            r_ag <= gl[W-1] ? al : (!gu[W-1] && gu != '0) ? au : '0;
            r_af <= (au <= al) ? al : au;
            r_bb_isect <= (qlo <= oup) && (qup >= olo);
            r_bb_size_ok <= (i_qh >= i_oh);
            r_bb_inside <= (olo > qlo) && (oup < qup);
            r_face <= gl[W-1] || (!gu[W-1] && gu != '0) || (gl <= W'(i_r))
                || ((-gu) <= W'(i_r));
            r_pt_in <= (W'(i_oc) >= qlo) && (W'(i_oc) <= qup);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctr <= P'(r_ad) * P'(r_ad);
            r_gap <= P'(r_ag) * P'(r_ag);
            r_far <= P'(r_af) * P'(r_af);
        end
    end

    assign o_ctr_sq = r_ctr[2*COORD_BITS+1:0];
    assign o_gap_sq = r_gap[2*COORD_BITS+1:0];
    assign o_far_sq = r_far[2*COORD_BITS+1:0];
    assign o_bb_isect = r_bb_isect;
    assign o_bb_size_ok = r_bb_size_ok;
    assign o_bb_inside = r_bb_inside;
    assign o_face = r_face;
    assign o_pt_in = r_pt_in;
endmodule

/* sv/bounding_volume_overlap_test.sv */
// Top level of the bounding volume overlap test pipeline.
`timescale 1ns / 1ps
`include "bounding_volume_overlap_test_macros.svh"
// Tests one object per transaction against a query sphere or box held in registers.
// The slave channel carries command and object kind in s_axis_tuser and the object
// center and sizes in s_axis_tdata; the master channel returns the hit flag.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while idle.
// The pipeline has four register stages: one for bounds and differences, one for
// squaring, one for the axis sums and one for the final compares and selection.
// A result moves through these stages in order and waits in the output register
// until taken. The squaring multipliers set the stage depth. Throughput is one
// transaction per cycle while the receiver does not stall. All stages advance
// together on a common enable, so a stalled receiver freezes the whole pipeline
// and nothing is lost or repeated; s_axis_tready drops only when the output
// register is full and not being taken.
// Reset clears all valid bits and the query registers to zero.
module bounding_volume_overlap_test
    import bvo_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0: object_center_x, y, z, object_size_x, y, z, zero pad.
    input  logic [((6*COORD_BITS-3)+7)/8*8-1:0] s_axis_tdata,
    // Fields from bit 0: command, object_kind.
    input  logic [2:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0: hit, zero pad.
    output logic [7:0] m_axis_tdata,
    input  logic i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data
);
    localparam int C = COORD_BITS;
    localparam int S = COORD_BITS - 1;
    localparam int Q = 2 * COORD_BITS + 2;
    localparam int T = Q + 2;

    logic r_kind;
    logic signed [C-1:0] r_qc [3];
    logic [S-1:0] r_qh [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_SPHERE;
            for (int i = 0; i < 3; i++) begin
                r_qc[i] <= '0;
                r_qh[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KIND: r_kind <= i_cfg_data[0];
                REG_CX: r_qc[0] <= i_cfg_data;
                REG_CY: r_qc[1] <= i_cfg_data;
                REG_CZ: r_qc[2] <= i_cfg_data;
                REG_SX: r_qh[0] <= i_cfg_data[S-1:0];
                REG_SY: r_qh[1] <= i_cfg_data[S-1:0];
                REG_SZ: r_qh[2] <= i_cfg_data[S-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [3:0] r_v;
    assign en = !r_v[3] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[2:0], s_axis_tvalid};
    end

    logic [1:0] cmd;
    logic okind;
    logic [S-1:0] oh [3];
    logic [S-1:0] rad;
    logic signed [C-1:0] oc [3];
    assign cmd = s_axis_tuser[1:0];
    assign okind = s_axis_tuser[2];
    assign oc[0] = s_axis_tdata[C-1:0];
    assign oc[1] = s_axis_tdata[2*C-1:C];
    assign oc[2] = s_axis_tdata[3*C-1:2*C];
    assign oh[0] = s_axis_tdata[3*C+S-1:3*C];
    assign oh[1] = s_axis_tdata[3*C+2*S-1:3*C+S];
    assign oh[2] = s_axis_tdata[3*C+3*S-1:3*C+2*S];
    assign rad = r_kind ? oh[0] : r_qh[0];

    logic [Q-1:0] gap [3], far [3], ctr [3];
    logic [2:0] bbi, bbs, bbn, face, pin;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        bvo_axis #(.COORD_BITS(C)) u_axis (
            .i_clk(i_clk), .i_en(en),
            .i_qc(r_qc[a]), .i_qh(r_qh[a]), .i_oc(oc[a]), .i_oh(oh[a]),
            .i_q_box(r_kind), .i_r(rad),
            .o_gap_sq(gap[a]), .o_far_sq(far[a]), .o_ctr_sq(ctr[a]),
            .o_bb_isect(bbi[a]), .o_bb_size_ok(bbs[a]), .o_bb_inside(bbn[a]),
            .o_face(face[a]), .o_pt_in(pin[a])
        );
    end

    // Control travelling alongside the data.
    typedef struct packed {
        logic [1:0] cmd;
        logic       okind;
        logic       qkind;
        logic       rb_gt;
    } t_ctl;

    t_ctl r_c1, r_c2, r_c3;
    logic [S:0] r_rsum, r_rdif;
    logic [S-1:0] r_r1;
    logic [2*S+1:0] r_sum_sq, r_dif_sq, r_r_sq;
    logic [T-1:0] r_gs, r_fs, r_cs;
    logic [2:0] r_bbi, r_bbs, r_bbn, r_face, r_pin;
    logic [2:0] r2_bbi, r2_bbs, r2_bbn, r2_face, r2_pin;
    logic [2*S+1:0] r_sq_sum, r_sq_dif, r_sq_r;
    logic n_hit;
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= '{cmd: cmd, okind: okind, qkind: r_kind, rb_gt: oh[0] > r_qh[0]};
            r_rsum <= {1'b0, r_qh[0]} + {1'b0, oh[0]};
            r_rdif <= {1'b0, r_qh[0]} - {1'b0, oh[0]};
            r_r1 <= rad;
            r_c2 <= r_c1;
            r_sum_sq <= (2*S+2)'(r_rsum) * (2*S+2)'(r_rsum);
            r_dif_sq <= (2*S+2)'(r_rdif) * (2*S+2)'(r_rdif);
            r_r_sq <= (2*S+2)'(r_r1) * (2*S+2)'(r_r1);
            r_bbi <= bbi; r_bbs <= bbs; r_bbn <= bbn; r_face <= face; r_pin <= pin;
            r_c3 <= r_c2;
            r_gs <= T'(gap[0]) + T'(gap[1]) + T'(gap[2]);
            r_fs <= T'(far[0]) + T'(far[1]) + T'(far[2]);
            r_cs <= T'(ctr[0]) + T'(ctr[1]) + T'(ctr[2]);
            r2_bbi <= r_bbi; r2_bbs <= r_bbs; r2_bbn <= r_bbn;
            r2_face <= r_face; r2_pin <= r_pin;
            r_sq_sum <= r_sum_sq; r_sq_dif <= r_dif_sq; r_sq_r <= r_r_sq;
            r_hit <= n_hit;
        end
    end

    always_comb begin
        n_hit = 1'b0;
        unique case (r_c3.cmd)
            CMD_INTERSECT: begin
                if (r_c3.qkind == KIND_SPHERE && r_c3.okind == KIND_SPHERE)
                    n_hit = r_cs <= T'(r_sq_sum);
                else if (r_c3.qkind == KIND_BOX && r_c3.okind == KIND_BOX)
                    n_hit = &r2_bbi;
                else
                    n_hit = r_gs <= T'(r_sq_r);
            end
            CMD_CONTAIN: begin
                if (r_c3.qkind == KIND_SPHERE && r_c3.okind == KIND_SPHERE)
                    n_hit = !r_c3.rb_gt && (r_cs < T'(r_sq_dif));
                else if (r_c3.qkind == KIND_SPHERE)
                    n_hit = (r_gs <= T'(r_sq_r)) && (T'(r_sq_r) <= r_fs);
                else if (r_c3.okind == KIND_SPHERE)
                    n_hit = (|r2_face) && (r_gs <= T'(r_sq_r));
                else
                    n_hit = (&r2_bbs) && (&r2_bbn);
            end
            CMD_POINT: begin
                if (r_c3.qkind == KIND_BOX) n_hit = &r2_pin;
                else n_hit = r_cs < T'(r_sq_r);
            end
            default: n_hit = 1'b0;
        endcase
    end

    assign m_axis_tvalid = r_v[3];
    assign m_axis_tdata = {7'd0, r_hit};

    `BVO_ASSERT_IMP(a_stall_ready, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `BVO_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(r_v))
    `BVO_ASSERT_NEXT(a_advance, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v[0])
endmodule

/* verif/tb.sv */
// Self-checking testbench for the bounding volume overlap test block.
`timescale 1ns / 1ps
module tb;
    import bvo_pkg::*;

    localparam int CB = 32;
    localparam int TDW = ((6*CB-3)+7)/8*8;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CB-1:0] i_cfg_data = '0;

    typedef struct packed {
        logic [1:0] cmd;
        logic kind;
        logic signed [CB-1:0] cx, cy, cz;
        logic [CB-2:0] sx, sy, sz;
    } t_obj;

    typedef struct packed {
        logic signed [CB-1:0] cx, cy, cz;
        logic [CB-2:0] sx, sy, sz;
    } t_vol;

    typedef logic [127:0] t_wide;
    typedef logic signed [CB+1:0] t_ext;

    bounding_volume_overlap_test #(.COORD_BITS(CB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic q_kind;
    t_vol qv;
    bit hit_queue[$];
    int mismatches = 0;
    int idle_cnt = 0;
    bit quiet = 0;
    bit sink_on = 0;

    function automatic t_wide sqr(t_ext d);
        logic [CB+1:0] m;
        m = d < 0 ? -d : d;
        return t_wide'(m) * t_wide'(m);
    endfunction

    function automatic t_ext lo_of(t_vol v, int i);
        logic signed [CB-1:0] c[3];
        logic [CB-2:0] s[3];
        c = '{v.cx, v.cy, v.cz};
        s = '{v.sx, v.sy, v.sz};
        return t_ext'(c[i]) - t_ext'({1'b0, s[i]});
    endfunction

    function automatic t_ext up_of(t_vol v, int i);
        logic signed [CB-1:0] c[3];
        logic [CB-2:0] s[3];
        c = '{v.cx, v.cy, v.cz};
        s = '{v.sx, v.sy, v.sz};
        return t_ext'(c[i]) + t_ext'({1'b0, s[i]});
    endfunction

    function automatic t_ext ctr(t_vol v, int i);
        logic signed [CB-1:0] c[3];
        c = '{v.cx, v.cy, v.cz};
        return t_ext'(c[i]);
    endfunction

    function automatic t_ext hsz(t_vol v, int i);
        logic [CB-2:0] s[3];
        s = '{v.sx, v.sy, v.sz};
        return t_ext'({1'b0, s[i]});
    endfunction

    function automatic t_wide ctr_dist(t_vol a, t_vol b);
        t_wide s;
        s = 0;
        for (int i = 0; i < 3; i++) s += sqr(ctr(a, i) - ctr(b, i));
        return s;
    endfunction

    function automatic t_wide gap_to_box(t_vol p, t_vol b);
        t_wide s;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (ctr(p, i) < lo_of(b, i)) s += sqr(ctr(p, i) - lo_of(b, i));
            else if (ctr(p, i) > up_of(b, i)) s += sqr(ctr(p, i) - up_of(b, i));
        end
        return s;
    endfunction

    function automatic bit overlap_hit(t_obj it);
        t_vol o, q;
        t_wide r2, dmax, d1, d2;
        bit ok;
        t_ext r;
        o = '{it.cx, it.cy, it.cz, it.sx, it.sy, it.sz};
        q = qv;
        case (it.cmd)
            CMD_INTERSECT: begin
                if (q_kind == KIND_SPHERE && it.kind == KIND_SPHERE) begin
                    r = hsz(q, 0) + hsz(o, 0);
                    return ctr_dist(q, o) <= sqr(r);
                end else if (q_kind == KIND_SPHERE)
                    return gap_to_box(q, o) <= sqr(hsz(q, 0));
                else if (it.kind == KIND_SPHERE)
                    return gap_to_box(o, q) <= sqr(hsz(o, 0));
                for (int i = 0; i < 3; i++)
                    if (!(lo_of(q, i) <= up_of(o, i) && up_of(q, i) >= lo_of(o, i)))
                        return 0;
                return 1;
            end
            CMD_CONTAIN: begin
                if (q_kind == KIND_SPHERE && it.kind == KIND_SPHERE) begin
                    if (hsz(o, 0) > hsz(q, 0)) return 0;
                    return ctr_dist(q, o) < sqr(hsz(q, 0) - hsz(o, 0));
                end else if (q_kind == KIND_SPHERE) begin
                    r2 = sqr(hsz(q, 0));
                    dmax = 0;
                    for (int i = 0; i < 3; i++) begin
                        d1 = sqr(ctr(q, i) - lo_of(o, i));
                        d2 = sqr(ctr(q, i) - up_of(o, i));
                        dmax += (d2 <= d1) ? d1 : d2;
                    end
                    return gap_to_box(q, o) <= r2 && r2 <= dmax;
                end else if (it.kind == KIND_SPHERE) begin
                    r = hsz(o, 0);
                    ok = 0;
                    for (int i = 0; i < 3; i++) begin
                        if (ctr(o, i) < lo_of(q, i) || ctr(o, i) > up_of(q, i)) ok = 1;
                        else if (ctr(o, i) - lo_of(q, i) <= r) ok = 1;
                        else if (up_of(q, i) - ctr(o, i) <= r) ok = 1;
                    end
                    return ok && gap_to_box(o, q) <= sqr(r);
                end
                for (int i = 0; i < 3; i++) if (hsz(q, i) < hsz(o, i)) return 0;
                for (int i = 0; i < 3; i++)
                    if (!(lo_of(o, i) > lo_of(q, i) && up_of(o, i) < up_of(q, i)))
                        return 0;
                return 1;
            end
            CMD_POINT: begin
                if (q_kind == KIND_SPHERE) return ctr_dist(q, o) < sqr(hsz(q, 0));
                for (int i = 0; i < 3; i++)
                    if (!(ctr(o, i) >= lo_of(q, i) && ctr(o, i) <= up_of(q, i))) return 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            REG_KIND: q_kind = val[0];
            REG_CX: qv.cx = val;
            REG_CY: qv.cy = val;
            REG_CZ: qv.cz = val;
            REG_SX: qv.sx = val[CB-2:0];
            REG_SY: qv.sy = val[CB-2:0];
            REG_SZ: qv.sz = val[CB-2:0];
            default: ;
        endcase
    endtask

    task automatic set_query(logic k, logic [CB-1:0] cx, cy, cz, sx, sy, sz);
        write_reg(REG_KIND, {31'd0, k});
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_CZ, cz);
        write_reg(REG_SX, sx);
        write_reg(REG_SY, sy);
        write_reg(REG_SZ, sz);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Sends one transaction; known < 0 means the predictor supplies the answer.
    task automatic send(t_obj it, int known);
        bit exp_hit;
        exp_hit = overlap_hit(it);
        if (known >= 0 && exp_hit != bit'(known)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees: table %0d predictor %0b", known, exp_hit);
        end
        while (!quiet && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser <= {it.kind, it.cmd};
        s_axis_tdata <= TDW'({it.sz, it.sy, it.sx, it.cz, it.cy, it.cx});
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hit_queue.push_back(known >= 0 ? bit'(known) : exp_hit);
        @(negedge i_clk);
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
        endcase
    endfunction

    function automatic logic [CB-2:0] rnd_size();
        case ($urandom_range(5))
            0: return 31'h7fff_ffff;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h18000));
        endcase
    endfunction

    function automatic t_obj rnd_obj();
        t_obj it;
        it.cmd = ($urandom_range(19) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
        it.kind = 1'($urandom_range(1));
        it.cx = rnd_coord();
        it.cy = rnd_coord();
        it.cz = rnd_coord();
        it.sx = rnd_size();
        it.sy = rnd_size();
        it.sz = rnd_size();
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result hit=%0b", m_axis_tdata[0]);
            end else begin
                if (m_axis_tdata[0] !== hit_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected %0b actual %0b",
                                 hit_queue[0], m_axis_tdata[0]);
                end
                void'(hit_queue.pop_front());
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= sink_on && (quiet || $urandom_range(99) >= 12);

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    t_obj rows[$];
    int row_hit[$];

    initial begin
        t_obj it;
        q_kind = KIND_SPHERE;
        qv = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1;
        @(negedge i_clk);
        // After reset: zero sphere at the origin.
        rows.push_back('{CMD_POINT, KIND_SPHERE, 0, 0, 0, 0, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_INTERSECT, KIND_SPHERE, 0, 0, 0, 0, 0, 0}); row_hit.push_back(1);
        rows.push_back('{CMD_CONTAIN, KIND_SPHERE, 0, 0, 0, 0, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_UNUSED, KIND_BOX, 0, 0, 0, 5, 5, 5}); row_hit.push_back(0);
        rows.push_back('{CMD_INTERSECT, KIND_BOX, 0, 0, 0, 0, 0, 0}); row_hit.push_back(1);
        foreach (rows[i]) send(rows[i], row_hit[i]);
        drain();
        // Sphere of radius 10 at the origin.
        set_query(KIND_SPHERE, 0, 0, 0, 10, 0, 0);
        rows = {}; row_hit = {};
        rows.push_back('{CMD_POINT, KIND_SPHERE, 10, 0, 0, 0, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_POINT, KIND_SPHERE, 9, 0, 0, 0, 0, 0}); row_hit.push_back(1);
        rows.push_back('{CMD_INTERSECT, KIND_SPHERE, 15, 0, 0, 5, 0, 0}); row_hit.push_back(1);
        rows.push_back('{CMD_INTERSECT, KIND_SPHERE, 16, 0, 0, 5, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_CONTAIN, KIND_SPHERE, 0, 0, 0, 11, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_CONTAIN, KIND_SPHERE, 4, 0, 0, 5, 0, 0}); row_hit.push_back(1);
        rows.push_back('{CMD_CONTAIN, KIND_SPHERE, 5, 0, 0, 5, 0, 0}); row_hit.push_back(0);
        rows.push_back('{CMD_CONTAIN, KIND_BOX, 0, 0, 0, 3, 3, 3}); row_hit.push_back(-1);
        rows.push_back('{CMD_INTERSECT, KIND_BOX, 20, 0, 0, 10, 1, 1}); row_hit.push_back(1);
        foreach (rows[i]) send(rows[i], row_hit[i]);
        drain();
        // Box with extreme center and extents.
        set_query(KIND_BOX, 32'h8000_0000, 32'h7fff_ffff, 0,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        rows = {}; row_hit = {};
        rows.push_back('{CMD_POINT, KIND_BOX, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0});
        row_hit.push_back(1);
        rows.push_back('{CMD_CONTAIN, KIND_BOX, 0, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff,
                         31'h7fff_ffff});
        row_hit.push_back(0);
        rows.push_back('{CMD_INTERSECT, KIND_SPHERE, 32'h7fff_ffff, 32'h8000_0000,
                         32'h8000_0000, 31'h7fff_ffff, 0, 0});
        row_hit.push_back(-1);
        rows.push_back('{CMD_CONTAIN, KIND_SPHERE, 0, 0, 0, 31'h7fff_ffff, 0, 0});
        row_hit.push_back(-1);
        rows.push_back('{CMD_INTERSECT, KIND_BOX, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff, 0, 0, 0});
        row_hit.push_back(-1);
        foreach (rows[i]) send(rows[i], row_hit[i]);
        drain();
        // Random phases with a fresh query each time.
        for (int ph = 0; ph < 10; ph++) begin
            set_query(1'($urandom_range(1)), rnd_coord(), rnd_coord(), rnd_coord(),
                      {1'b0, rnd_size()}, {1'b0, rnd_size()}, {1'b0, rnd_size()});
            quiet = (ph == 3);
            for (int n = 0; n < 125; n++) begin
                if (ph == 5 && n == 60) drain();
                it = rnd_obj();
                // Half the time, place the object near the query so the tests land on both answers.
                if ($urandom_range(1)) begin
                    it.cx = qv.cx + 32'($signed($urandom_range(0, 32'h30000)) - 32'sh18000);
                    it.cy = qv.cy + 32'($signed($urandom_range(0, 32'h30000)) - 32'sh18000);
                    it.cz = qv.cz + 32'($signed($urandom_range(0, 32'h30000)) - 32'sh18000);
                end
                send(it, -1);
            end
            drain();
        end
        quiet = 0;
        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* bounding_volume_overlap_test.f */
+incdir+sv
sv/bvo_pkg.sv
sv/bvo_axis.sv
sv/bounding_volume_overlap_test.sv
verif/tb.sv
